[hw/rtl/pcs_pkg.sv]
// Package: types, constants and compare functions of the Pareto connection set
`default_nettype none
package pcs_pkg;

  localparam int TIME_BITS     = 18;
  localparam int COST_BITS     = 32;
  localparam int TRACE_BITS    = 32;
  localparam int NT_BITS       = 4;
  localparam int OP_BITS       = 2;
  localparam int STATUS_BITS   = 3;
  localparam int REMOVED_BITS  = 5;
  localparam int MULT_BITS     = 16;
  localparam int IMP_ADD_BITS  = 32;
  localparam int JT_ADD_BITS   = 18;
  localparam int NT_ADD_BITS   = 12;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int SET_DEPTH_DEF = 16;

  localparam int COST_LO = COST_BITS / 2;
  localparam int COST_HI = COST_BITS - COST_LO;
  localparam int TIME_LO = TIME_BITS / 2;
  localparam int TIME_HI = TIME_BITS - TIME_LO;
  localparam int IMP_W   = MULT_BITS + COST_BITS + 1;
  localparam int JT_W    = MULT_BITS + TIME_BITS + 1;
  localparam int NT_W    = MULT_BITS + NT_BITS + 1;

  localparam logic [OP_BITS-1:0] OP_OFFER    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_FINALIZE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR    = 2'd2;
  localparam logic [OP_BITS-1:0] OP_UNUSED   = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_REJECTED = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_KEPT     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NONE     = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_CLEARED  = 3'd5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TOL_MODE  = 3'd0,
    CFG_NO_DIRECT = 3'd1,
    CFG_IMP_GAIN  = 3'd2,
    CFG_IMP_ADD   = 3'd3,
    CFG_JT_MULT   = 3'd4,
    CFG_JT_ADD    = 3'd5,
    CFG_NT_MULT   = 3'd6,
    CFG_NT_ADD    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [OP_BITS-1:0]    operation;
    logic [TIME_BITS-1:0]  depart_time;
    logic [TIME_BITS-1:0]  arrive_time;
    logic [TIME_BITS-1:0]  journey_secs;
    logic [COST_BITS-1:0]  cost_value;
    logic [NT_BITS-1:0]    transfers;
    logic [TRACE_BITS-1:0] trace_key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic [REMOVED_BITS-1:0] removed_count;
    logic [TIME_BITS-1:0]    out_depart;
    logic [TIME_BITS-1:0]    out_arrive;
    logic [TIME_BITS-1:0]    out_journey;
    logic [COST_BITS-1:0]    out_cost;
    logic [NT_BITS-1:0]      out_transfers;
    logic [TRACE_BITS-1:0]   out_trace;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  dep;
    logic [TIME_BITS-1:0]  arr;
    logic [TIME_BITS-1:0]  jt;
    logic [COST_BITS-1:0]  cost;
    logic [NT_BITS-1:0]    nt;
    logic [TRACE_BITS-1:0] trace;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEXT,
    CELL_PREV,
    CELL_CAND
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      mark_gone;
    logic      clear;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic gone;
    logic rej;
    logic drop;
    logic less;
  } cell_flags_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP,
    S_COMPACT,
    S_INSERT,
    S_MIN,
    S_PROD,
    S_BOUND,
    S_SCAN,
    S_FLUSH,
    S_CLEAR
  } state_t;

  function automatic logic dominates(input entry_t a, input entry_t b, input logic no_direct);
    logic even_or_better;
    logic better;
    even_or_better = (a.dep >= b.dep) && (a.arr <= b.arr) && (a.cost <= b.cost) &&
                     (a.nt <= b.nt);
    better   = (a.dep > b.dep) || (a.arr < b.arr) || (a.cost < b.cost) || (a.nt < b.nt);
    return !(no_direct && (a.nt == '0)) && even_or_better && better;
  endfunction

  function automatic logic order_less(input entry_t a, input entry_t b);
    logic r;
    if (a.dep != b.dep) begin
      r = a.dep < b.dep;
    end else if (a.arr != b.arr) begin
      r = a.arr < b.arr;
    end else if (a.cost != b.cost) begin
      r = a.cost < b.cost;
    end else if (a.nt != b.nt) begin
      r = a.nt < b.nt;
    end else begin
      r = a.trace < b.trace;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pcs_cell.sv]
// One cell of the entry chain: holds an entry, compares it with the candidate
`default_nettype none
module pcs_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pcs_pkg::cell_ctl_t  ctl,
  input  wire pcs_pkg::entry_t     cand,
  input  wire logic                no_direct,
  input  wire pcs_pkg::entry_t     prev_entry,
  input  wire logic                prev_valid,
  input  wire logic                prev_gone,
  input  wire pcs_pkg::entry_t     next_entry,
  input  wire logic                next_valid,
  input  wire logic                next_gone,
  output pcs_pkg::entry_t          entry,
  output pcs_pkg::cell_flags_t     flags
);

  logic valid;
  logic gone;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
      gone  <= 1'b0;
    end else begin
      case (ctl.cmd)
        pcs_pkg::CELL_NEXT: begin
          valid <= next_valid;
          gone  <= next_gone;
        end
        pcs_pkg::CELL_PREV: begin
          valid <= prev_valid;
          gone  <= prev_gone;
        end
        pcs_pkg::CELL_CAND: begin
          valid <= 1'b1;
          gone  <= 1'b0;
        end
        default: begin
          gone <= gone | ctl.mark_gone;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      pcs_pkg::CELL_NEXT: entry <= next_entry;
      pcs_pkg::CELL_PREV: entry <= prev_entry;
      pcs_pkg::CELL_CAND: entry <= cand;
      default:            entry <= entry;
    endcase
  end

  always_comb begin
    flags.valid = valid;
    flags.gone  = gone;
    flags.rej   = valid && ((entry.trace == cand.trace) ||
                            pcs_pkg::dominates(entry, cand, no_direct));
    flags.drop  = valid && pcs_pkg::dominates(cand, entry, no_direct);
    flags.less  = valid && pcs_pkg::order_less(cand, entry);
  end

endmodule
`default_nettype wire

[hw/rtl/pareto_connection_set.sv]
// Top level of the Pareto connection set: control, tolerance bounds, cell chain
// An offer runs through its states in order: S_CMP compares the candidate against every
// cell at once, S_COMPACT closes the gap by shifting the chain once per removed entry
// until it sees no gap left, and S_INSERT shifts in the candidate. A rejected offer, or
// one that finds the store full, answers from S_CMP. Finalize rotates the ring of
// SET_DEPTH cells twice, once to find the minima and once to emit. One transaction is
// in flight at a time and the next is accepted in the cycle after the last result is
// written; results wait in an output register meanwhile.
`default_nettype none
module pareto_connection_set #(
  parameter int SET_DEPTH = pcs_pkg::SET_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire pcs_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output pcs_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_we,
  input  wire logic [pcs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [pcs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int STEP_W = $clog2(SET_DEPTH);
  localparam int RCNT_W = $clog2(SET_DEPTH + 1);

  pcs_pkg::state_t state, state_next;

  logic                              tol_mode, no_direct;
  logic [pcs_pkg::MULT_BITS-1:0]     imp_gain, jt_mult, nt_mult;
  logic [pcs_pkg::IMP_ADD_BITS-1:0]  imp_add;
  logic [pcs_pkg::JT_ADD_BITS-1:0]   jt_add;
  logic [pcs_pkg::NT_ADD_BITS-1:0]   nt_add;

  pcs_pkg::entry_t       cand, pend;
  logic                  have_pend;
  logic [RCNT_W-1:0]     removed;
  logic [STEP_W-1:0]     step;
  logic [pcs_pkg::COST_BITS-1:0] min_cost;
  logic [pcs_pkg::TIME_BITS-1:0] min_jt;
  logic [pcs_pkg::NT_BITS-1:0]   min_nt;
  logic [pcs_pkg::MULT_BITS+pcs_pkg::COST_LO-1:0] p_cost_lo;
  logic [pcs_pkg::MULT_BITS+pcs_pkg::COST_HI-1:0] p_cost_hi;
  logic [pcs_pkg::MULT_BITS+pcs_pkg::TIME_LO-1:0] p_jt_lo;
  logic [pcs_pkg::MULT_BITS+pcs_pkg::TIME_HI-1:0] p_jt_hi;
  logic [pcs_pkg::MULT_BITS+pcs_pkg::NT_BITS-1:0] p_nt;
  logic [pcs_pkg::IMP_W-1:0] imp_bound;
  logic [pcs_pkg::JT_W-1:0]  jt_bound;
  logic [pcs_pkg::NT_W-1:0]  nt_bound;

  pcs_pkg::entry_t      ent [SET_DEPTH];
  pcs_pkg::cell_flags_t flg [SET_DEPTH];
  pcs_pkg::cell_ctl_t   ctl [SET_DEPTH];

  logic [SET_DEPTH-1:0] rej_v, drop_v, gone_v, gone_pre, ins;
  logic any_rej, any_drop, any_gone, full;
  logic in_acc, out_free, step_last, keep0, advance;
  logic emit;
  pcs_pkg::out_item_t emit_data;
  pcs_pkg::entry_t    in_entry;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign step_last = (step == STEP_W'(SET_DEPTH - 1));
  assign in_stall  = (state != pcs_pkg::S_IDLE);

  always_comb begin
    in_entry.dep   = in_data.depart_time;
    in_entry.arr   = in_data.arrive_time;
    in_entry.jt    = in_data.journey_secs;
    in_entry.cost  = in_data.cost_value;
    in_entry.nt    = in_data.transfers;
    in_entry.trace = in_data.trace_key;
  end

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    localparam int NI = (i + 1) % SET_DEPTH;
    localparam int PI = (i == 0) ? 0 : i - 1;
    pcs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl[i]),
      .cand       (cand),
      .no_direct  (no_direct),
      .prev_entry (ent[PI]),
      .prev_valid (flg[PI].valid),
      .prev_gone  (flg[PI].gone),
      .next_entry (ent[NI]),
      .next_valid (flg[NI].valid),
      .next_gone  (flg[NI].gone),
      .entry      (ent[i]),
      .flags      (flg[i])
    );
    assign rej_v[i]  = flg[i].rej;
    assign drop_v[i] = flg[i].drop;
    assign gone_v[i] = flg[i].gone;
    if (i == 0) begin : g_first
      assign gone_pre[i] = flg[i].gone;
      assign ins[i]      = flg[i].valid ? flg[i].less : 1'b1;
    end else begin : g_rest
      assign gone_pre[i] = gone_pre[i-1] | flg[i].gone;
      assign ins[i]      = flg[i].valid ? flg[i].less : flg[i-1].valid;
    end
  end

  assign any_rej  = |rej_v;
  assign any_drop = |drop_v;
  assign any_gone = |gone_v;
  assign full     = flg[SET_DEPTH-1].valid && !any_drop;

  assign keep0 = flg[0].valid && (!tol_mode ||
    (((pcs_pkg::IMP_W'(ent[0].cost) << 8) <= imp_bound) &&
     ((pcs_pkg::JT_W'(ent[0].jt) << 8) <= jt_bound) &&
     ((pcs_pkg::NT_W'(ent[0].nt) << 8) <= nt_bound)));
  assign advance = !(keep0 && have_pend && !out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      pcs_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.operation)
            pcs_pkg::OP_OFFER:    state_next = pcs_pkg::S_CMP;
            pcs_pkg::OP_FINALIZE: state_next = pcs_pkg::S_MIN;
            pcs_pkg::OP_CLEAR:    state_next = pcs_pkg::S_CLEAR;
            default:              state_next = pcs_pkg::S_IDLE;
          endcase
        end
      end
      pcs_pkg::S_CMP: begin
        if (out_free) begin
          state_next = (any_rej || full) ? pcs_pkg::S_IDLE : pcs_pkg::S_COMPACT;
        end
      end
      pcs_pkg::S_COMPACT: begin
        if (!any_gone) state_next = pcs_pkg::S_INSERT;
      end
      pcs_pkg::S_INSERT: begin
        if (out_free) state_next = pcs_pkg::S_IDLE;
      end
      pcs_pkg::S_MIN: begin
        if (step_last) state_next = pcs_pkg::S_PROD;
      end
      pcs_pkg::S_PROD:  state_next = pcs_pkg::S_BOUND;
      pcs_pkg::S_BOUND: state_next = pcs_pkg::S_SCAN;
      pcs_pkg::S_SCAN: begin
        if (advance && step_last) state_next = pcs_pkg::S_FLUSH;
      end
      pcs_pkg::S_FLUSH: begin
        if (out_free) state_next = pcs_pkg::S_IDLE;
      end
      pcs_pkg::S_CLEAR: begin
        if (out_free) state_next = pcs_pkg::S_IDLE;
      end
      default: state_next = pcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    for (int i = 0; i < SET_DEPTH; i++) begin
      ctl[i].cmd       = pcs_pkg::CELL_HOLD;
      ctl[i].mark_gone = 1'b0;
      ctl[i].clear     = 1'b0;
    end
    unique case (state)
      pcs_pkg::S_CMP: begin
        if (out_free) begin
          if (any_rej) begin
            emit             = 1'b1;
            emit_data.status = pcs_pkg::ST_REJECTED;
            emit_data.last   = 1'b1;
          end else if (full) begin
            emit             = 1'b1;
            emit_data.status = pcs_pkg::ST_FULL;
            emit_data.last   = 1'b1;
          end else begin
            for (int i = 0; i < SET_DEPTH; i++) ctl[i].mark_gone = drop_v[i];
          end
        end
      end
      pcs_pkg::S_COMPACT: begin
        if (any_gone) begin
          for (int i = 0; i < SET_DEPTH; i++) begin
            if (gone_pre[i]) ctl[i].cmd = pcs_pkg::CELL_NEXT;
          end
          ctl[SET_DEPTH-1].clear = 1'b1;
        end
      end
      pcs_pkg::S_INSERT: begin
        if (out_free) begin
          for (int i = 0; i < SET_DEPTH; i++) begin
            if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
              ctl[i].cmd = pcs_pkg::CELL_PREV;
            end else if (ins[i]) begin
              ctl[i].cmd = pcs_pkg::CELL_CAND;
            end
          end
          emit                    = 1'b1;
          emit_data.status        = pcs_pkg::ST_ACCEPTED;
          emit_data.removed_count = pcs_pkg::REMOVED_BITS'(removed);
          emit_data.last          = 1'b1;
        end
      end
      pcs_pkg::S_MIN: begin
        for (int i = 0; i < SET_DEPTH; i++) ctl[i].cmd = pcs_pkg::CELL_NEXT;
      end
      pcs_pkg::S_SCAN: begin
        if (advance) begin
          for (int i = 0; i < SET_DEPTH; i++) ctl[i].cmd = pcs_pkg::CELL_NEXT;
          if (keep0 && have_pend) begin
            emit                    = 1'b1;
            emit_data.status        = pcs_pkg::ST_KEPT;
            emit_data.out_depart    = pend.dep;
            emit_data.out_arrive    = pend.arr;
            emit_data.out_journey   = pend.jt;
            emit_data.out_cost      = pend.cost;
            emit_data.out_transfers = pend.nt;
            emit_data.out_trace     = pend.trace;
          end
        end
      end
      pcs_pkg::S_FLUSH: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
          if (have_pend) begin
            emit_data.status        = pcs_pkg::ST_KEPT;
            emit_data.out_depart    = pend.dep;
            emit_data.out_arrive    = pend.arr;
            emit_data.out_journey   = pend.jt;
            emit_data.out_cost      = pend.cost;
            emit_data.out_transfers = pend.nt;
            emit_data.out_trace     = pend.trace;
          end else begin
            emit_data.status = pcs_pkg::ST_NONE;
          end
        end
      end
      pcs_pkg::S_CLEAR: begin
        if (out_free) begin
          for (int i = 0; i < SET_DEPTH; i++) ctl[i].clear = 1'b1;
          emit             = 1'b1;
          emit_data.status = pcs_pkg::ST_CLEARED;
          emit_data.last   = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_mode  <= 1'b0;
      no_direct <= 1'b0;
      imp_gain  <= pcs_pkg::MULT_BITS'(256);
      imp_add   <= '0;
      jt_mult   <= pcs_pkg::MULT_BITS'(256);
      jt_add    <= '0;
      nt_mult   <= pcs_pkg::MULT_BITS'(256);
      nt_add    <= '0;
    end else if (cfg_we) begin
      unique case (pcs_pkg::cfg_idx_t'(cfg_index))
        pcs_pkg::CFG_TOL_MODE:  tol_mode  <= cfg_data[0];
        pcs_pkg::CFG_NO_DIRECT: no_direct <= cfg_data[0];
        pcs_pkg::CFG_IMP_GAIN:  imp_gain  <= cfg_data[pcs_pkg::MULT_BITS-1:0];
        pcs_pkg::CFG_IMP_ADD:   imp_add   <= cfg_data[pcs_pkg::IMP_ADD_BITS-1:0];
        pcs_pkg::CFG_JT_MULT:   jt_mult   <= cfg_data[pcs_pkg::MULT_BITS-1:0];
        pcs_pkg::CFG_JT_ADD:    jt_add    <= cfg_data[pcs_pkg::JT_ADD_BITS-1:0];
        pcs_pkg::CFG_NT_MULT:   nt_mult   <= cfg_data[pcs_pkg::MULT_BITS-1:0];
        pcs_pkg::CFG_NT_ADD:    nt_add    <= cfg_data[pcs_pkg::NT_ADD_BITS-1:0];
        default:                tol_mode  <= tol_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == pcs_pkg::S_BOUND) begin
        have_pend <= 1'b0;
      end else if (state == pcs_pkg::S_SCAN && advance && keep0) begin
        have_pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= emit_data;
    if (in_acc) begin
      cand     <= in_entry;
      step     <= '0;
      removed  <= '0;
      min_cost <= '1;
      min_jt   <= '1;
      min_nt   <= '1;
    end
    if (state == pcs_pkg::S_COMPACT && any_gone) removed <= removed + RCNT_W'(1);
    if (state == pcs_pkg::S_MIN) begin
      step <= step + STEP_W'(1);
      if (flg[0].valid) begin
        if (ent[0].cost < min_cost) min_cost <= ent[0].cost;
        if (ent[0].jt < min_jt)     min_jt   <= ent[0].jt;
        if (ent[0].nt < min_nt)     min_nt   <= ent[0].nt;
      end
    end
    if (state == pcs_pkg::S_PROD) begin
      p_cost_lo <= imp_gain * min_cost[pcs_pkg::COST_LO-1:0];
      p_cost_hi <= imp_gain * min_cost[pcs_pkg::COST_BITS-1:pcs_pkg::COST_LO];
      p_jt_lo   <= jt_mult * min_jt[pcs_pkg::TIME_LO-1:0];
      p_jt_hi   <= jt_mult * min_jt[pcs_pkg::TIME_BITS-1:pcs_pkg::TIME_LO];
      p_nt      <= nt_mult * min_nt;
    end
    if (state == pcs_pkg::S_BOUND) begin
      step      <= '0;
      imp_bound <= (pcs_pkg::IMP_W'(p_cost_hi) << pcs_pkg::COST_LO) +
                   pcs_pkg::IMP_W'(p_cost_lo) + (pcs_pkg::IMP_W'(imp_add) << 8);
      jt_bound  <= (pcs_pkg::JT_W'(p_jt_hi) << pcs_pkg::TIME_LO) +
                   pcs_pkg::JT_W'(p_jt_lo) + (pcs_pkg::JT_W'(jt_add) << 8);
      nt_bound  <= pcs_pkg::NT_W'(p_nt) + pcs_pkg::NT_W'(nt_add);
    end
    if (state == pcs_pkg::S_SCAN && advance) begin
      step <= step + STEP_W'(1);
      if (keep0) pend <= ent[0];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pcs_checker.sv]
// Port checker for the Pareto connection set, bound to the top level
`default_nettype none
module pcs_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire pcs_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire pcs_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.operation != pcs_pkg::OP_UNUSED) |=> in_stall)
    else $error("new transaction taken while one is in flight");

  a_last_unless_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != pcs_pkg::ST_KEPT) |-> out_data.last)
    else $error("non-entry result without last");

  a_removed_only_accepted: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != pcs_pkg::ST_ACCEPTED) |-> out_data.removed_count == '0)
    else $error("removed count on a result other than accepted");

endmodule

bind pareto_connection_set pcs_checker u_pcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
